[sv/u8d_pkg.sv]
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; imported by every module of the block.
package u8d_pkg;

   localparam int unsigned NumCont = 3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_LEAD = 2'd1;
   localparam logic [1:0] ST_NUL      = 2'd2;
   localparam logic [1:0] ST_BAD_CONT = 2'd3;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_ONE  = 3'd1;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;

   typedef struct packed {
      logic       nul;
      logic       bad_cont;
      logic [5:0] payload;
   } lane_result_type;

   typedef struct packed {
      logic       bad_lead;
      logic       nul;
      logic [2:0] len;
      logic [6:0] bits;
   } lead_info_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  len;
      logic [1:0]  status;
   } result_type;

endpackage

[sv/u8d_lead.sv]
// Lead byte decode: sequence length, lead payload bits, NUL flag and lead errors.
// Depends on u8d_pkg.
module u8d_lead (
   input  logic [7:0]             lead_byte,
   output u8d_pkg::lead_info_type info
);
   import u8d_pkg::*;

   always_comb begin
      info = '0;
      info.nul = (lead_byte == 8'h00);
      if (lead_byte[7] == 1'b0) begin
         info.len  = LEN_ONE;
         info.bits = lead_byte[6:0];
      end else if (lead_byte[7:5] == 3'b110) begin
         info.len  = LEN_TWO;
         info.bits = {2'b00, lead_byte[4:0]};
      end else if (lead_byte[7:4] == 4'b1110) begin
         info.len  = LEN_THREE;
         info.bits = {3'b000, lead_byte[3:0]};
      end else if (lead_byte[7:3] == 5'b11110) begin
         info.len  = LEN_FOUR;
         info.bits = {4'b0000, lead_byte[2:0]};
      end else begin
         info.bad_lead = 1'b1;
         info.len      = LEN_NONE;
      end
   end

endmodule

[sv/u8d_lane.sv]
// One continuation byte lane: NUL check, 10xxxxxx form check, payload.
// Depends on u8d_pkg.
module u8d_lane (
   input  logic [7:0]               cont_byte,
   output u8d_pkg::lane_result_type lane
);
   import u8d_pkg::*;

   assign lane.nul      = (cont_byte == 8'h00);
   assign lane.bad_cont = (cont_byte[7:6] != 2'b10);
   assign lane.payload  = cont_byte[5:0];

endmodule

[sv/u8d_merge.sv]
// Merge of lead decode and lane results into one decoded result.
// Depends on u8d_pkg.
module u8d_merge (
   input  logic [7:0]               lead_byte,
   input  u8d_pkg::lead_info_type   info,
   input  u8d_pkg::lane_result_type lanes [u8d_pkg::NumCont],
   output u8d_pkg::result_type      result
);
   import u8d_pkg::*;

   logic [20:0] value;

   always_comb begin
      value = 21'd0;
      case (info.len)
         LEN_ONE:   value = {14'd0, info.bits};
         LEN_TWO:   value = {10'd0, info.bits[4:0], lanes[0].payload};
         LEN_THREE: value = {5'd0, info.bits[3:0], lanes[0].payload, lanes[1].payload};
         LEN_FOUR:  value = {info.bits[2:0], lanes[0].payload, lanes[1].payload,
                             lanes[2].payload};
         default:   value = 21'd0;
      endcase
   end

   always_comb begin
      result = '0;
      if (info.bad_lead) begin
         result.status = ST_BAD_LEAD;
      end else if (info.nul) begin
         result.status = ST_NUL;
      end else if (info.len >= LEN_TWO && lanes[0].nul) begin
         result.status = ST_NUL;
      end else if (info.len >= LEN_TWO && lanes[0].bad_cont) begin
         result.status = ST_BAD_CONT;
      end else if (info.len >= LEN_THREE && lanes[1].nul) begin
         result.status = ST_NUL;
      end else if (info.len >= LEN_THREE && lanes[1].bad_cont) begin
         result.status = ST_BAD_CONT;
      end else if (info.len == LEN_FOUR && lanes[2].nul) begin
         result.status = ST_NUL;
      end else if (info.len == LEN_FOUR && lanes[2].bad_cont) begin
         result.status = ST_BAD_CONT;
      end else if (value > MAX_SCALAR) begin
         result.status     = ST_OK;
         result.code_point = {13'd0, lead_byte};
         result.len        = LEN_ONE;
      end else begin
         result.status     = ST_OK;
         result.code_point = value;
         result.len        = info.len;
      end
   end

endmodule

[sv/utf8_code_point_decoder_unit.sv]
// Top level of the UTF-8 code point decoder: lead decode, three
// continuation lanes, merge, output register and skid register.
// Depends on u8d_pkg, u8d_lead, u8d_lane and u8d_merge.
//
//   channel   direction  ports
//   req_      in         req_valid, req_ready, req_byte0..req_byte3
//   rsp_      out        rsp_valid, rsp_ready, rsp_code_point, rsp_length, rsp_status
//
// One window per cycle while the skid register is empty; each result is registered before it shows on rsp_.
// Decode is a single pass through the lanes and the merge into the output register.
// A skid register takes one more window while the output register is stalled.
// Synchronous reset empties both registers.
module utf8_code_point_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte0,
   input  logic [7:0]  req_byte1,
   input  logic [7:0]  req_byte2,
   input  logic [7:0]  req_byte3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_length,
   output logic [1:0]  rsp_status
);
   import u8d_pkg::*;

   lead_info_type   info;
   lane_result_type lanes [NumCont];
   logic [7:0]      cont_bytes [NumCont];
   result_type      decoded;

   result_type out_ff, out_in, skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic       accept, pop;

   assign cont_bytes[0] = req_byte1;
   assign cont_bytes[1] = req_byte2;
   assign cont_bytes[2] = req_byte3;

   u8d_lead u_lead (
      .lead_byte (req_byte0),
      .info      (info)
   );

   for (genvar g = 0; g < NumCont; g++) begin : g_lane
      u8d_lane u_lane (
         .cont_byte (cont_bytes[g]),
         .lane      (lanes[g])
      );
   end

   u8d_merge u_merge (
      .lead_byte (req_byte0),
      .info      (info),
      .lanes     (lanes),
      .result    (decoded)
   );

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = decoded;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = decoded;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_ff.code_point;
   assign rsp_length     = out_ff.len;
   assign rsp_status     = out_ff.status;

endmodule

[verif/tb_utf8_code_point_decoder_unit.sv]
`timescale 1ns / 1ps
// Testbench for utf8_code_point_decoder_unit: directed and random byte windows with
// bursty request traffic and a stalling receiver, checked against an in-bench decoder.
// Depends on u8d_pkg and the decoder RTL.

class code_point_scoreboard;
   u8d_pkg::result_type expected_points[$];
   int unsigned mismatches;

   function u8d_pkg::result_type decode_window(logic [31:0] window);
      u8d_pkg::result_type r;
      logic [7:0]  lead;
      logic [7:0]  cont;
      logic [31:0] acc;
      logic [2:0]  seq_len;
      lead         = window[7:0];
      r.code_point = '0;
      r.len        = u8d_pkg::LEN_NONE;
      r.status     = u8d_pkg::ST_OK;
      if (lead[7] == 1'b0) begin
         seq_len = u8d_pkg::LEN_ONE;
         acc     = {25'd0, lead[6:0]};
      end else if (lead[7:5] == 3'b110) begin
         seq_len = u8d_pkg::LEN_TWO;
         acc     = {27'd0, lead[4:0]};
      end else if (lead[7:4] == 4'b1110) begin
         seq_len = u8d_pkg::LEN_THREE;
         acc     = {28'd0, lead[3:0]};
      end else if (lead[7:3] == 5'b11110) begin
         seq_len = u8d_pkg::LEN_FOUR;
         acc     = {29'd0, lead[2:0]};
      end else begin
         r.status = u8d_pkg::ST_BAD_LEAD;
         return r;
      end
      if (lead == 8'h00) begin
         r.status = u8d_pkg::ST_NUL;
         return r;
      end
      for (int i = 1; i < seq_len; i++) begin
         cont = window[8*i +: 8];
         if (cont == 8'h00) begin
            r.status = u8d_pkg::ST_NUL;
            return r;
         end
         if (cont[7:6] != 2'b10) begin
            r.status = u8d_pkg::ST_BAD_CONT;
            return r;
         end
         acc = {acc[25:0], cont[5:0]};
      end
      if (acc > {11'd0, u8d_pkg::MAX_SCALAR}) begin
         r.code_point = {13'd0, lead};
         r.len        = u8d_pkg::LEN_ONE;
      end else begin
         r.code_point = acc[20:0];
         r.len        = seq_len;
      end
      return r;
   endfunction

   function void note_window(logic [31:0] window);
      expected_points.push_back(decode_window(window));
   endfunction

   function void check_result(logic [20:0] code_point, logic [2:0] length,
                              logic [1:0] status);
      u8d_pkg::result_type want;
      if (expected_points.size() == 0) begin
         $error("unexpected transfer: code_point %h length %0d status %0d",
                code_point, length, status);
         mismatches++;
         return;
      end
      want = expected_points.pop_front();
      if (code_point !== want.code_point) begin
         $error("code_point: expected %h, actual %h", want.code_point, code_point);
         mismatches++;
      end
      if (length !== want.len) begin
         $error("length: expected %0d, actual %0d", want.len, length);
         mismatches++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, status);
         mismatches++;
      end
   endfunction
endclass

module tb_utf8_code_point_decoder_unit;
   import u8d_pkg::*;

   localparam int unsigned RandomWindows = 1000;
   localparam int unsigned CycleLimit    = 200000;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte0 = 8'h00;
   logic [7:0]  req_byte1 = 8'h00;
   logic [7:0]  req_byte2 = 8'h00;
   logic [7:0]  req_byte3 = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [20:0] rsp_code_point;
   logic [2:0]  rsp_length;
   logic [1:0]  rsp_status;

   code_point_scoreboard sb;
   int unsigned burst_left = 0;
   int unsigned cycles = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int unsigned ready_run = 0;

   utf8_code_point_decoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte0      (req_byte0),
      .req_byte1      (req_byte1),
      .req_byte2      (req_byte2),
      .req_byte3      (req_byte3),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_length     (rsp_length),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: switch at random between stall patterns
   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_run  = $urandom_range(20, 150);
      end else begin
         ready_run--;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (ready_run[2:1] != 2'b00);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_code_point, rsp_length, rsp_status);
      end
   end

   // hold the window until the transfer; open a new burst after a random gap
   task automatic send_window(input logic [31:0] window);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_byte0 <= window[7:0];
      req_byte1 <= window[15:8];
      req_byte2 <= window[23:16];
      req_byte3 <= window[31:24];
      do @(posedge clock); while (!req_ready);
      sb.note_window(window);
   endtask

   function automatic logic [31:0] well_formed(int unsigned seq_len);
      logic [31:0] window;
      logic [31:0] rnd;
      window = $urandom;
      rnd    = $urandom;
      case (seq_len)
         1: window[7:0] = {1'b0, rnd[6:0]};
         2: window[7:0] = {3'b110, rnd[4:0]};
         3: window[7:0] = {4'b1110, rnd[3:0]};
         default: window[7:0] = {5'b11110, rnd[2:0]};
      endcase
      for (int i = 1; i < seq_len; i++) begin
         rnd = $urandom;
         window[8*i +: 8] = {2'b10, rnd[5:0]};
      end
      return window;
   endfunction

   // damage one byte inside the sequence: NUL, bad lead or bad continuation
   function automatic logic [31:0] broken(int unsigned seq_len);
      logic [31:0] window;
      logic [31:0] rnd;
      int unsigned pos;
      window = well_formed(seq_len);
      pos    = $urandom_range(0, seq_len - 1);
      rnd    = $urandom;
      if (rnd[9:8] == 2'b00) begin
         window[8*pos +: 8] = 8'h00;
      end else if (pos == 0) begin
         window[7:0] = rnd[10] ? {2'b10, rnd[5:0]} : {5'b11111, rnd[2:0]};
      end else begin
         window[8*pos +: 8] = {rnd[7:6] ^ 2'b10 ^ {1'b0, rnd[10] | ~rnd[11]} ,
                               rnd[5:0]};
         if (window[8*pos + 6 +: 2] == 2'b10) window[8*pos + 7] = 1'b0;
      end
      return window;
   endfunction

   initial begin
      logic [31:0] directed[$];
      int unsigned pick;
      sb = new;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed = '{
         32'h0000_0000, 32'hFFFF_FF7F, 32'h0000_0041, 32'h0000_0080,
         32'h0000_00BF, 32'h0000_00F8, 32'h0000_00FF, 32'h0000_A9C2,
         32'h0000_80C0, 32'h0000_00C3, 32'h0000_41C3, 32'h0000_C0C3,
         32'h00AC_82E2, 32'h00BF_BFEF, 32'h0041_82E2, 32'h0000_82E2,
         32'h8098_9FF0, 32'hBFBF_8FF4, 32'h8080_90F4, 32'hBFBF_BFF7,
         32'h7F98_9FF0, 32'h0098_9FF0, 32'h0000_FF41, 32'hFF00_A9C3
      };
      foreach (directed[i]) send_window(directed[i]);

      for (int unsigned n = 0; n < RandomWindows; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            send_window(well_formed($urandom_range(1, 4)));
         end else if (pick < 8) begin
            send_window(broken($urandom_range(1, 4)));
         end else begin
            send_window($urandom);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/u8d_pkg.sv
sv/u8d_lead.sv
sv/u8d_lane.sv
sv/u8d_merge.sv
sv/utf8_code_point_decoder_unit.sv
verif/tb_utf8_code_point_decoder_unit.sv
